### src/arx_pkg.sv
// Shared constants, types and coefficient helpers for the ARX plant model step.
package arx_pkg;

    localparam int A_TAPS      = 4;
    localparam int B_TAPS      = 4;
    localparam int MAX_DELAY   = 16;
    localparam int PACKED_TAPS = 4;
    localparam int CTRL_DEPTH  = MAX_DELAY + B_TAPS;
    localparam int NUM_TAPS    = A_TAPS + B_TAPS;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PACKED_W   = PACKED_TAPS * COEF_W;
    localparam int DELAY_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int FRAC_SHIFT = 12;

    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS) + 1;
    localparam int Y_W    = ACC_W - FRAC_SHIFT + 1;

    localparam int CTRL_AW   = $clog2(CTRL_DEPTH);
    localparam int OUT_AW    = $clog2(A_TAPS);
    localparam int CCNT_W    = $clog2(CTRL_DEPTH + 1);
    localparam int YCNT_W    = $clog2(A_TAPS + 1);
    localparam int AGE_W     = CTRL_AW + 1;
    localparam int LAST_STEP = NUM_TAPS + 2;
    localparam int STEP_W    = $clog2(LAST_STEP + 1);

    localparam logic [CFG_IDX_W-1:0] REG_A_COEF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B_COEF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HI   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_EN   = 3'd7;

    localparam logic [PACKED_W-1:0] RST_A_COEF  = 64'h0000_0000_0000_F99A;
    localparam logic [PACKED_W-1:0] RST_B_COEF  = 64'h0000_0000_0000_099A;
    localparam logic [DELAY_W-1:0]  RST_DELAY   = 5'd1;
    localparam logic [SAMPLE_W-1:0] RST_LO      = 16'hD800;
    localparam logic [SAMPLE_W-1:0] RST_HI      = 16'h2800;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    function automatic t_coef tap_of(input logic [PACKED_W-1:0] packed_c,
                                     input logic [STEP_W-1:0] idx);
        t_coef c;
        c = '0;
        if (int'(idx) < PACKED_TAPS) begin
            c = packed_c[int'(idx) * COEF_W +: COEF_W];
        end
        return c;
    endfunction

endpackage

### src/arx_if.sv
// Valid/ready channel interfaces for input samples, model output and register writes.
interface arx_in_if;
    logic              valid;
    logic              ready;
    arx_pkg::t_sample  control_in;
    arx_pkg::t_sample  noise_in;
    modport source (output valid, output control_in, output noise_in, input ready);
    modport sink   (input valid, input control_in, input noise_in, output ready);
endinterface

interface arx_out_if;
    logic              valid;
    logic              ready;
    arx_pkg::t_sample  model_out;
    modport source (output valid, output model_out, input ready);
    modport sink   (input valid, input model_out, output ready);
endinterface

interface arx_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [arx_pkg::CFG_IDX_W-1:0]       index;
    logic [arx_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/arx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/arx_plant_model_step.sv
// Top level: ARX plant model, one output sample per control/noise input transaction.
// Each input transaction clamps the control sample (when limits are enabled), pushes it into
// a 20-entry control history RAM and then runs eight multiply-accumulate steps through one
// shared 16x16 multiplier: four input taps read from the control history RAM and four
// feedback taps read from a 4-entry output history RAM, one RAM read per step. Read, multiply
// and accumulate are separate register stages; an item goes through acceptance, eight reads,
// pipeline drain and result load (held while an earlier result is pending), and a new item is
// taken in the cycle after the result is loaded into the output register, even while that
// result still waits to be taken. History entries not yet written read as zero through fill
// counts, so no clearing pass follows reset. Register writes are taken in any cycle and
// must only be issued while the block is idle.
module arx_plant_model_step (
    input  logic       i_clk,
    input  logic       i_rst_n,
    arx_in_if.sink     i_in,
    arx_cfg_if.sink    i_cfg,
    arx_out_if.source  o_out
);
    import arx_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                   r_state;
    logic [STEP_W-1:0]      r_step;

    logic [PACKED_W-1:0]    r_a_coef;
    logic [PACKED_W-1:0]    r_b_coef;
    logic [DELAY_W-1:0]     r_delay;
    t_sample                r_ctrl_lo;
    t_sample                r_ctrl_hi;
    t_sample                r_out_lo;
    t_sample                r_out_hi;
    logic                   r_lim_en;

    logic [CTRL_AW-1:0]     r_cwp;
    logic [CCNT_W-1:0]      r_ccnt;
    logic [OUT_AW-1:0]      r_ywp;
    logic [YCNT_W-1:0]      r_ycnt;

    t_sample                r_noise;
    t_coef                  r_coef1;
    logic                   r_zero1;
    logic                   r_fb1;
    logic signed [PROD_W-1:0] r_prod;
    logic                   r_fb2;
    logic signed [ACC_W-1:0]  r_acc;

    t_sample                r_out;
    logic                   r_out_valid;

    logic                   in_acc;
    logic                   cfg_acc;
    logic                   issue;
    logic                   finish;
    logic                   acc_en;
    t_sample                u_lim;
    logic [DELAY_W-1:0]     d_eff;
    logic [AGE_W-1:0]       c_age;
    logic [AGE_W-1:0]       c_off;
    logic [AGE_W-1:0]       c_addr_w;
    logic [CTRL_AW-1:0]     c_raddr;
    logic                   c_valid;
    logic [STEP_W-1:0]      a_idx;
    logic [OUT_AW-1:0]      y_raddr;
    logic                   y_valid;
    logic                   is_fb;
    t_coef                  coef;
    t_sample                c_rdata;
    t_sample                y_rdata;
    t_sample                op;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [Y_W-1:0]  y_sum;
    logic signed [Y_W-1:0]  y_lim;
    t_sample                y_sat;
    logic [CTRL_AW-1:0]     n_cwp;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    assign issue  = (r_state == ST_RUN) && (int'(r_step) < NUM_TAPS);
    assign acc_en = (r_state == ST_RUN) && (int'(r_step) >= 2) && (int'(r_step) < LAST_STEP);
    assign finish = (r_state == ST_RUN) && (r_step == STEP_W'(LAST_STEP))
                    && (!r_out_valid || o_out.ready);

    always_comb begin
        u_lim = i_in.control_in;
        if (r_lim_en) begin
            if (i_in.control_in < r_ctrl_lo) begin
                u_lim = r_ctrl_lo;
            end else if (i_in.control_in > r_ctrl_hi) begin
                u_lim = r_ctrl_hi;
            end
        end
    end

    always_comb begin
        if (r_delay == '0) begin
            d_eff = DELAY_W'(1);
        end else if (int'(r_delay) > MAX_DELAY) begin
            d_eff = DELAY_W'(MAX_DELAY);
        end else begin
            d_eff = r_delay;
        end
    end

    always_comb begin
        c_age = AGE_W'(d_eff) + AGE_W'(r_step);
        c_off = c_age + AGE_W'(1);
        if (AGE_W'(r_cwp) >= c_off) begin
            c_addr_w = AGE_W'(r_cwp) - c_off;
        end else begin
            c_addr_w = AGE_W'(r_cwp) + AGE_W'(CTRL_DEPTH) - c_off;
        end
        c_raddr = c_addr_w[CTRL_AW-1:0];
        c_valid = c_age < AGE_W'(r_ccnt);
        a_idx   = r_step - STEP_W'(B_TAPS);
        y_raddr = r_ywp - OUT_AW'(1) - a_idx[OUT_AW-1:0];
        y_valid = YCNT_W'(a_idx) < r_ycnt;
        is_fb   = int'(r_step) >= B_TAPS;
        coef    = is_fb ? tap_of(r_a_coef, a_idx) : tap_of(r_b_coef, r_step);
    end

    assign n_cwp = (int'(r_cwp) == CTRL_DEPTH - 1) ? '0 : r_cwp + CTRL_AW'(1);

    arx_ram #(.WIDTH(SAMPLE_W), .DEPTH(CTRL_DEPTH)) u_ctrl_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_cwp),
        .i_wdata (u_lim),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    arx_ram #(.WIDTH(SAMPLE_W), .DEPTH(A_TAPS)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (finish),
        .i_waddr (r_ywp),
        .i_wdata (y_sat),
        .i_raddr (y_raddr),
        .o_rdata (y_rdata)
    );

    assign op = r_zero1 ? '0 : (r_fb1 ? y_rdata : c_rdata);

    always_comb begin
        acc_sh = r_acc >>> FRAC_SHIFT;
        y_sum  = Y_W'(acc_sh) + Y_W'(r_noise);
        y_lim  = y_sum;
        if (r_lim_en) begin
            if (y_sum < Y_W'(r_out_lo)) begin
                y_lim = Y_W'(r_out_lo);
            end else if (y_sum > Y_W'(r_out_hi)) begin
                y_lim = Y_W'(r_out_hi);
            end
        end
        if (y_lim < Y_W'(signed'(16'sh8000))) begin
            y_sat = 16'sh8000;
        end else if (y_lim > Y_W'(signed'(16'sh7FFF))) begin
            y_sat = 16'sh7FFF;
        end else begin
            y_sat = y_lim[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_coef  <= RST_A_COEF;
            r_b_coef  <= RST_B_COEF;
            r_delay   <= RST_DELAY;
            r_ctrl_lo <= RST_LO;
            r_ctrl_hi <= RST_HI;
            r_out_lo  <= RST_LO;
            r_out_hi  <= RST_HI;
            r_lim_en  <= 1'b1;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                REG_A_COEF:  r_a_coef  <= i_cfg.data[PACKED_W-1:0];
                REG_B_COEF:  r_b_coef  <= i_cfg.data[PACKED_W-1:0];
                REG_DELAY:   r_delay   <= i_cfg.data[DELAY_W-1:0];
                REG_CTRL_LO: r_ctrl_lo <= i_cfg.data[SAMPLE_W-1:0];
                REG_CTRL_HI: r_ctrl_hi <= i_cfg.data[SAMPLE_W-1:0];
                REG_OUT_LO:  r_out_lo  <= i_cfg.data[SAMPLE_W-1:0];
                REG_OUT_HI:  r_out_hi  <= i_cfg.data[SAMPLE_W-1:0];
                REG_LIM_EN:  r_lim_en  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_cwp       <= '0;
            r_ccnt      <= '0;
            r_ywp       <= '0;
            r_ycnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_RUN;
                        r_step  <= '0;
                        r_cwp   <= n_cwp;
                        if (int'(r_ccnt) < CTRL_DEPTH) begin
                            r_ccnt <= r_ccnt + CCNT_W'(1);
                        end
                    end
                end
                ST_RUN: begin
                    if (int'(r_step) < LAST_STEP) begin
                        r_step <= r_step + STEP_W'(1);
                    end else if (finish) begin
                        r_state <= ST_IDLE;
                        r_ywp   <= r_ywp + OUT_AW'(1);
                        if (int'(r_ycnt) < A_TAPS) begin
                            r_ycnt <= r_ycnt + YCNT_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_noise <= i_in.noise_in;
            r_acc   <= '0;
        end else if (acc_en) begin
            if (r_fb2) begin
                r_acc <= r_acc - ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_coef1 <= coef;
        r_fb1   <= is_fb;
        r_zero1 <= !issue || (is_fb ? !y_valid : !c_valid);
        r_prod  <= op * r_coef1;
        r_fb2   <= r_fb1;
        if (finish) begin
            r_out <= y_sat;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.model_out = r_out;

`ifndef SYNTHESIS
    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_RUN) && (r_step == '0))
        else $error("accepted transaction did not start the tap sequence");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == ST_RUN && r_step == STEP_W'(LAST_STEP)))
        else $error("result appeared without a completed tap sequence");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid && $stable(o_out.model_out))
        else $error("pending result was lost or changed");

    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_ccnt) <= CTRL_DEPTH) && (int'(r_ycnt) <= A_TAPS)
        && (int'(r_cwp) < CTRL_DEPTH))
        else $error("history pointer or fill count out of range");
`endif

endmodule

### bench/arx_plant_model_step_test.sv
// Self-checking testbench for arx_plant_model_step: directed and random sample streams.
module arx_plant_model_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    import arx_pkg::*;

    class plant_output_tracker;
        logic [PACKED_W-1:0] a_coef;
        logic [PACKED_W-1:0] b_coef;
        logic [DELAY_W-1:0]  delay_reg;
        t_sample             ctrl_lo;
        t_sample             ctrl_hi;
        t_sample             out_lo;
        t_sample             out_hi;
        logic                lim_en;
        t_sample             ctrl_hist [CTRL_DEPTH];
        t_sample             out_hist [A_TAPS];
        t_sample             expected_outputs [$];
        int                  mismatch_count;

        function new();
            a_coef = RST_A_COEF;
            b_coef = RST_B_COEF;
            delay_reg = RST_DELAY;
            ctrl_lo = RST_LO;
            ctrl_hi = RST_HI;
            out_lo = RST_LO;
            out_hi = RST_HI;
            lim_en = 1'b1;
            foreach (ctrl_hist[k]) ctrl_hist[k] = '0;
            foreach (out_hist[k]) out_hist[k] = '0;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_A_COEF:  a_coef = value;
                REG_B_COEF:  b_coef = value;
                REG_DELAY:   delay_reg = value[DELAY_W-1:0];
                REG_CTRL_LO: ctrl_lo = value[SAMPLE_W-1:0];
                REG_CTRL_HI: ctrl_hi = value[SAMPLE_W-1:0];
                REG_OUT_LO:  out_lo = value[SAMPLE_W-1:0];
                REG_OUT_HI:  out_hi = value[SAMPLE_W-1:0];
                REG_LIM_EN:  lim_en = value[0];
                default: ;
            endcase
        endfunction

        function longint bound(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint coef_at(logic [PACKED_W-1:0] packed_c, int k);
            if (k >= PACKED_TAPS) return 0;
            return longint'(t_coef'(packed_c[k*COEF_W +: COEF_W]));
        endfunction

        function void take_sample(t_sample control, t_sample noise);
            longint u;
            longint y;
            longint acc;
            int     d;
            d = int'(delay_reg);
            if (d < 1) d = 1;
            if (d > MAX_DELAY) d = MAX_DELAY;
            u = control;
            if (lim_en) u = bound(u, ctrl_lo, ctrl_hi);
            for (int k = CTRL_DEPTH - 1; k > 0; k--) ctrl_hist[k] = ctrl_hist[k-1];
            ctrl_hist[0] = t_sample'(u);
            acc = 0;
            for (int k = 0; k < B_TAPS; k++) begin
                if (d + k < CTRL_DEPTH) acc += coef_at(b_coef, k) * longint'(ctrl_hist[d+k]);
            end
            for (int k = 0; k < A_TAPS; k++) begin
                acc -= coef_at(a_coef, k) * longint'(out_hist[k]);
            end
            y = (acc >>> FRAC_SHIFT) + longint'(noise);
            if (lim_en) y = bound(y, out_lo, out_hi);
            y = bound(y, -32768, 32767);
            for (int k = A_TAPS - 1; k > 0; k--) out_hist[k] = out_hist[k-1];
            out_hist[0] = t_sample'(y);
            expected_outputs = {expected_outputs, t_sample'(y)};
        endfunction

        function void check_output(t_sample got);
            t_sample want;
            if (expected_outputs.size() == 0) begin
                mismatch_count++;
                $display("%0t: model_out %0d with no transaction outstanding", $time, got);
                return;
            end
            want = expected_outputs[0];
            expected_outputs.delete(0);
            if (got !== want) begin
                mismatch_count++;
                $display("%0t: model_out mismatch, expected %0d, actual %0d",
                         $time, want, got);
            end
        endfunction
    endclass

    localparam int     RUN_ITEMS    = 1750;
    localparam int     TAIL_CYCLES  = 24;
    localparam longint RUN_LIMIT_NS = 4_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    arx_in_if  in_if();
    arx_out_if out_if();
    arx_cfg_if cfg_if();

    plant_output_tracker tracker;
    bit send_steady;
    bit take_steady;
    int sent_count;

    arx_plant_model_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int idle_cycles(bit steady);
        if (steady) return 0;
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom_range(1, 3);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic t_sample draw_sample();
        case ($urandom_range(0, 7))
            0: return t_sample'(32767);
            1: return t_sample'(-32768);
            2: return '0;
            3, 4: return t_sample'($urandom);
            default: return t_sample'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic t_sample draw_noise();
        case ($urandom_range(0, 7))
            0: return t_sample'($urandom);
            1: return '0;
            default: return t_sample'(int'($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_coefs(bit calm);
        logic [CFG_DATA_W-1:0] packed_c;
        t_coef c;
        packed_c = '0;
        for (int k = 0; k < PACKED_TAPS; k++) begin
            if (calm) begin
                c = t_coef'(int'($urandom_range(0, 1800)) - 900);
            end else begin
                case ($urandom_range(0, 5))
                    0: c = '0;
                    1: c = 16'h7FFF;
                    2: c = 16'h8000;
                    3: c = t_coef'($urandom);
                    default: c = t_coef'(int'($urandom_range(0, 4000)) - 2000);
                endcase
            end
            packed_c[k*COEF_W +: COEF_W] = c;
        end
        return packed_c;
    endfunction

    task automatic send_sample(t_sample control, t_sample noise);
        int gap;
        gap = idle_cycles(send_steady);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.control_in <= control;
        in_if.noise_in   <= noise;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        tracker.take_sample(control, noise);
        sent_count++;
    endtask

    task automatic wait_for_outputs();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_outputs.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        tracker.set_register(idx, value);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase();
        int      count;
        bit      calm;
        t_sample lo;
        t_sample hi;
        wait_for_outputs();
        calm = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) write_register(REG_A_COEF, draw_coefs(calm));
        if ($urandom_range(0, 1)) write_register(REG_B_COEF, draw_coefs(calm));
        if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 3) == 0) write_register(REG_DELAY, 64'($urandom_range(0, 31)));
            else write_register(REG_DELAY, 64'($urandom_range(1, 16)));
        end
        for (int pair = 0; pair < 2; pair++) begin
            case ($urandom_range(0, 5))
                0: begin
                    lo = t_sample'(-32768);
                    hi = t_sample'(32767);
                end
                1: begin
                    hi = t_sample'(int'($urandom_range(0, 16000)) - 8000);
                    lo = t_sample'(int'(hi) + int'($urandom_range(1, 8000)));
                end
                default: begin
                    lo = t_sample'(-int'($urandom_range(0, 16000)));
                    hi = t_sample'($urandom_range(0, 16000));
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_register(pair == 0 ? REG_CTRL_LO : REG_OUT_LO, 64'(lo));
                write_register(pair == 0 ? REG_CTRL_HI : REG_OUT_HI, 64'(hi));
            end
        end
        if ($urandom_range(0, 2) == 0) write_register(REG_LIM_EN, 64'($urandom_range(0, 1)));
        send_steady = ($urandom_range(0, 3) == 0);
        take_steady = ($urandom_range(0, 3) == 0);
        count = $urandom_range(40, 160);
        repeat (count) begin
            send_sample(draw_sample(), draw_noise());
            if ($urandom_range(0, 199) == 0) wait_for_outputs();
        end
    endtask

    initial begin
        int gap;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = idle_cycles(take_steady);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            tracker.check_output(out_if.model_out);
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("arx_plant_model_step_test: done, errors");
        $finish;
    end

    initial begin
        int random_start;
        tracker = new();
        sent_count = 0;
        send_steady = 1'b0;
        take_steady = 1'b0;
        in_if.valid      <= 1'b0;
        in_if.control_in <= '0;
        in_if.noise_in   <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= REG_A_COEF;
        cfg_if.data      <= '0;
        i_rst_n          <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: both clamps active
        send_sample(t_sample'(32767), '0);
        send_sample(t_sample'(-32768), '0);
        send_sample('0, t_sample'(32767));
        send_sample('0, t_sample'(-32768));
        send_sample(t_sample'(10240), '0);
        send_sample(t_sample'(-10241), t_sample'(1));

        // limits off, extreme taps, zero delay: drive into saturation
        wait_for_outputs();
        write_register(REG_A_COEF, 64'h8000_8000_8000_8000);
        write_register(REG_B_COEF, 64'h7FFF_7FFF_7FFF_7FFF);
        write_register(REG_DELAY, 64'd0);
        write_register(REG_CTRL_LO, 64'(t_sample'(-32768)));
        write_register(REG_CTRL_HI, 64'(t_sample'(32767)));
        write_register(REG_OUT_LO, 64'(t_sample'(-32768)));
        write_register(REG_OUT_HI, 64'(t_sample'(32767)));
        write_register(REG_LIM_EN, 64'd0);
        repeat (3) send_sample(t_sample'(32767), t_sample'(32767));
        repeat (3) send_sample(t_sample'(-32768), t_sample'(-32768));
        send_sample(t_sample'(-1), '0);

        // inverted limits, delay above range
        wait_for_outputs();
        write_register(REG_A_COEF, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(REG_B_COEF, 64'h1000_F000_0800_1000);
        write_register(REG_DELAY, 64'd31);
        write_register(REG_CTRL_LO, 64'(t_sample'(1000)));
        write_register(REG_CTRL_HI, 64'(t_sample'(-1000)));
        write_register(REG_OUT_LO, 64'(t_sample'(500)));
        write_register(REG_OUT_HI, 64'(t_sample'(-500)));
        write_register(REG_LIM_EN, 64'd1);
        send_sample(t_sample'(2000), '0);
        send_sample(t_sample'(-2000), '0);
        send_sample('0, '0);
        send_sample(t_sample'(700), t_sample'(-700));
        send_sample(t_sample'(-32768), t_sample'(32767));
        send_sample(t_sample'(32767), t_sample'(-32768));

        random_start = sent_count;
        while (sent_count - random_start < RUN_ITEMS) random_phase();

        wait_for_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.expected_outputs.size() == 0) begin
            $display("arx_plant_model_step_test: done, clean");
        end else begin
            $display("arx_plant_model_step_test: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
src/arx_pkg.sv
src/arx_if.sv
src/arx_ram.sv
src/arx_plant_model_step.sv
bench/arx_plant_model_step_test.sv
